// ----- src/jsd_pkg.sv -----
// ---------------------------------------------------------------------------
// jsd_pkg
// Shared types and constants for the JSON string decoder.
// ---------------------------------------------------------------------------
package jsd_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned KEPT_W     = 12;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned CP_W       = 21;

  // default width of the kept byte counter
  localparam int unsigned LENGTH_BITS_DEF = 12;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KEEP_OUTPUT = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BYTE_LIMIT  = 8'd1;

  // configuration reset values
  localparam logic               KEEP_OUTPUT_RST = 1'b1;
  localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RST  = 12'd31;

  // status codes
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOLONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  // decoder phase codes
  localparam logic [PHASE_W-1:0] PH_WAIT = 4'd0;
  localparam logic [PHASE_W-1:0] PH_BODY = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ESC  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_Q1   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_Q2   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_Q3   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_Q4   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_SBS  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_SU   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_L1   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_L2   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_L3   = 4'd11;
  localparam logic [PHASE_W-1:0] PH_L4   = 4'd12;
  localparam logic [PHASE_W-1:0] PH_UTF  = 4'd13;

  // one input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } jsd_item_t;

  // configuration seen by the decoder
  typedef struct packed {
    logic               keep_output;
    logic [LIMIT_W-1:0] byte_limit;
  } jsd_cfg_t;

  // one result transaction
  typedef struct packed {
    logic [DATA_W-1:0]   out_data;
    logic [COUNT_W-1:0]  out_count;
    logic [STATUS_W-1:0] status;
    logic                done_res;
    logic [KEPT_W-1:0]   kept_length;
  } jsd_res_t;

endpackage

// ----- src/jsd_if.sv -----
// ---------------------------------------------------------------------------
// jsd_if
// Valid/ready channel interfaces of the JSON string decoder.
// ---------------------------------------------------------------------------

// raw byte stream
interface jsd_in_if import jsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// decoded result stream
interface jsd_out_if import jsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   out_data;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] status;
  logic                done_res;
  logic [KEPT_W-1:0]   kept_length;

  modport source (output valid, output out_data, output out_count, output status,
                  output done_res, output kept_length, input ready);
  modport sink   (input valid, input out_data, input out_count, input status,
                  input done_res, input kept_length, output ready);
endinterface

// configuration register writes
interface jsd_cfg_if import jsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ----- src/jsd_engine.sv -----
// ---------------------------------------------------------------------------
// jsd_engine
// String decode state and the per-byte next-state and result logic.
// ---------------------------------------------------------------------------
module jsd_engine import jsd_pkg::*; #(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  jsd_item_t item_i,
  input  jsd_cfg_t  cfg_i,
  output jsd_res_t  res_o
);

  localparam int unsigned CmpW = (LengthBits > LIMIT_W) ? LengthBits : LIMIT_W;
  localparam logic [LengthBits-1:0] CntMax = '1;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h6e;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;

  // hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  // decode state
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [15:0]           hex_q, hex_d;
  logic [9:0]            high_q, high_d;
  logic [CP_W-1:0]       u8acc_q, u8acc_d;
  logic [1:0]            u8left_q, u8left_d;
  logic [1:0]            u8tot_q, u8tot_d;
  logic [LengthBits-1:0] kept_q, kept_d;
  logic                  fits_q, fits_d;

  // step results
  logic                  bad, done, emit;
  logic [CP_W-1:0]       cp;
  logic [4:0]            hd;
  logic [15:0]           hex_new;
  logic [CP_W-1:0]       u8_new;
  logic [1:0]            u8left_new;
  logic [BYTE_W-1:0]     b;

  // encoder and packing
  logic [2:0]            enc_n, put_n, take;
  logic [BYTE_W-1:0]     enc_b [4];
  logic [CmpW-1:0]       lim_ext, lim_w;
  logic [LengthBits-1:0] lim, room;
  logic [LengthBits:0]   sum_w;
  logic [DATA_W-1:0]     packed_data;
  logic [CmpW-1:0]       kept_ext;

  assign b       = item_i.in_byte;
  assign hd      = hex_digit(b);
  assign hex_new = {hex_q[11:0], hd[3:0]};
  assign u8_new  = {u8acc_q[CP_W-7:0], b[5:0]};
  assign u8left_new = u8left_q - 2'd1;

  // per-byte phase logic
  always_comb begin
    phase_d  = phase_q;
    hex_d    = hex_q;
    high_d   = high_q;
    u8acc_d  = u8acc_q;
    u8left_d = u8left_q;
    u8tot_d  = u8tot_q;
    bad      = 1'b0;
    done     = 1'b0;
    emit     = 1'b0;
    cp       = '0;
    unique case (phase_q)
      PH_BODY: begin
        if (b == CH_QUOTE) done = 1'b1;
        else if (b < 8'h20) bad = 1'b1;
        else if (b == CH_BSL) phase_d = PH_ESC;
        else if (b < 8'h80) begin
          emit = 1'b1;
          cp   = CP_W'(b);
        end else if (b >= 8'hc2 && b <= 8'hdf) begin
          u8acc_d = CP_W'(b[4:0]); u8left_d = 2'd1; u8tot_d = 2'd1; phase_d = PH_UTF;
        end else if (b >= 8'he0 && b <= 8'hef) begin
          u8acc_d = CP_W'(b[3:0]); u8left_d = 2'd2; u8tot_d = 2'd2; phase_d = PH_UTF;
        end else if (b >= 8'hf0 && b <= 8'hf4) begin
          u8acc_d = CP_W'(b[2:0]); u8left_d = 2'd3; u8tot_d = 2'd3; phase_d = PH_UTF;
        end else bad = 1'b1;
      end
      PH_UTF: begin
        if (b[7:6] != 2'b10) bad = 1'b1;
        else begin
          u8acc_d  = u8_new;
          u8left_d = u8left_new;
          if (u8left_new == 2'd0) begin
            if ((u8tot_q == 2'd2 && u8_new < 21'h800) ||
                (u8tot_q == 2'd3 && u8_new < 21'h10000) ||
                (u8_new >= 21'hd800 && u8_new <= 21'hdfff) || u8_new > 21'h10ffff) begin
              bad = 1'b1;
            end else begin
              emit    = 1'b1;
              cp      = u8_new;
              phase_d = PH_BODY;
            end
          end
        end
      end
      PH_ESC: begin
        phase_d = PH_BODY;
        unique case (b)
          CH_QUOTE, CH_BSL, CH_SLASH: begin emit = 1'b1; cp = CP_W'(b); end
          CH_B: begin emit = 1'b1; cp = CP_W'(8'h08); end
          CH_F: begin emit = 1'b1; cp = CP_W'(8'h0c); end
          CH_N: begin emit = 1'b1; cp = CP_W'(8'h0a); end
          CH_R: begin emit = 1'b1; cp = CP_W'(8'h0d); end
          CH_T: begin emit = 1'b1; cp = CP_W'(8'h09); end
          CH_U: begin hex_d = '0; phase_d = PH_Q1; end
          default: bad = 1'b1;
        endcase
      end
      PH_Q1, PH_Q2, PH_Q3, PH_Q4: begin
        if (!hd[4]) bad = 1'b1;
        else begin
          hex_d = hex_new;
          if (phase_q != PH_Q4) phase_d = phase_q + 4'd1;
          else if (hex_new >= 16'hd800 && hex_new <= 16'hdbff) begin
            high_d  = hex_new[9:0];
            phase_d = PH_SBS;
          end else if (hex_new >= 16'hdc00 && hex_new <= 16'hdfff) bad = 1'b1;
          else begin
            emit    = 1'b1;
            cp      = CP_W'(hex_new);
            phase_d = PH_BODY;
          end
        end
      end
      PH_SBS: begin
        if (b == CH_BSL) phase_d = PH_SU;
        else bad = 1'b1;
      end
      PH_SU: begin
        if (b == CH_U) begin
          hex_d   = '0;
          phase_d = PH_L1;
        end else bad = 1'b1;
      end
      PH_L1, PH_L2, PH_L3, PH_L4: begin
        if (!hd[4]) bad = 1'b1;
        else begin
          hex_d = hex_new;
          if (phase_q != PH_L4) phase_d = phase_q + 4'd1;
          else if (hex_new < 16'hdc00 || hex_new > 16'hdfff) bad = 1'b1;
          else begin
            // low half bits never overlap the shifted high half
            emit    = 1'b1;
            cp      = 21'h10000 + CP_W'({high_q, hex_new[9:0]});
            phase_d = PH_BODY;
          end
        end
      end
      default: begin
        // waiting for the opening quote, unused codes included
        if (b == CH_QUOTE) begin
          phase_d  = PH_BODY;
          hex_d    = '0;
          high_d   = '0;
          u8acc_d  = '0;
          u8left_d = '0;
          u8tot_d  = '0;
        end else if (!(b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR)) begin
          bad = 1'b1;
        end
      end
    endcase
    if (!bad && !done && item_i.end_of_stream) bad = 1'b1;
  end

  // utf-8 encoder for the code point of this byte
  always_comb begin
    enc_b[1] = '0;
    enc_b[2] = '0;
    enc_b[3] = '0;
    if (cp <= 21'h7f) begin
      enc_n    = 3'd1;
      enc_b[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      enc_n    = 3'd2;
      enc_b[0] = {3'b110, cp[10:6]};
      enc_b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      enc_n    = 3'd3;
      enc_b[0] = {4'b1110, cp[15:12]};
      enc_b[1] = {2'b10, cp[11:6]};
      enc_b[2] = {2'b10, cp[5:0]};
    end else begin
      enc_n    = 3'd4;
      enc_b[0] = {5'b11110, cp[20:18]};
      enc_b[1] = {2'b10, cp[17:12]};
      enc_b[2] = {2'b10, cp[11:6]};
      enc_b[3] = {2'b10, cp[5:0]};
    end
  end

  // effective limit: smaller of byte_limit and counter maximum
  assign lim_ext = CmpW'(cfg_i.byte_limit);
  assign lim_w   = (lim_ext < CmpW'(CntMax)) ? lim_ext : CmpW'(CntMax);
  assign lim     = lim_w[LengthBits-1:0];
  assign put_n   = emit ? enc_n : 3'd0;
  assign room    = (lim > kept_q) ? (lim - kept_q) : '0;
  assign take    = (room >= LengthBits'(put_n)) ? put_n : room[2:0];
  assign sum_w   = {1'b0, kept_q} + (LengthBits + 1)'(put_n);

  // byte limit and counting
  always_comb begin
    fits_d = fits_q;
    if (cfg_i.keep_output) begin
      kept_d = kept_q + LengthBits'(take);
      if (take != put_n) fits_d = 1'b0;
    end else if (sum_w > (LengthBits + 1)'(CntMax)) begin
      kept_d = CntMax;
    end else begin
      kept_d = sum_w[LengthBits-1:0];
    end
  end

  // pack kept bytes, first byte lowest
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      packed_data[i*BYTE_W +: BYTE_W] = (3'(i) < take) ? enc_b[i] : '0;
    end
  end

  assign kept_ext = CmpW'(kept_d);

  // result of this byte
  always_comb begin
    res_o.kept_length = kept_ext[KEPT_W-1:0];
    res_o.done_res    = bad || done;
    if (bad) begin
      res_o.out_data  = '0;
      res_o.out_count = '0;
      res_o.status    = ST_INVALID;
    end else begin
      res_o.out_data  = cfg_i.keep_output ? packed_data : '0;
      res_o.out_count = cfg_i.keep_output ? take : 3'd0;
      res_o.status    = done ? (fits_d ? ST_OK : ST_TOOLONG) : ST_BUSY;
    end
  end

  // state update, string state clears when a string ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      hex_q    <= '0;
      high_q   <= '0;
      u8acc_q  <= '0;
      u8left_q <= '0;
      u8tot_q  <= '0;
      kept_q   <= '0;
      fits_q   <= 1'b1;
    end else if (advance_i) begin
      if (bad || done) begin
        phase_q  <= PH_WAIT;
        hex_q    <= '0;
        high_q   <= '0;
        u8acc_q  <= '0;
        u8left_q <= '0;
        u8tot_q  <= '0;
        kept_q   <= '0;
        fits_q   <= 1'b1;
      end else begin
        phase_q  <= phase_d;
        hex_q    <= hex_d;
        high_q   <= high_d;
        u8acc_q  <= u8acc_d;
        u8left_q <= u8left_d;
        u8tot_q  <= u8tot_d;
        kept_q   <= kept_d;
        fits_q   <= fits_d;
      end
    end
  end

endmodule

// ----- src/json_string_decoder.sv -----
// ---------------------------------------------------------------------------
// json_string_decoder
// Decodes one JSON string from a byte stream into UTF-8 with strict checks.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                        role
//  in_i     in   in_byte, end_of_stream                         raw bytes
//  out_o    out  out_data, out_count, status, done_res,         one result per byte
//                kept_length
//  cfg_i    in   addr, wdata                                    register writes
//
//  One byte per cycle sustained while out_o.ready holds; each byte gives exactly one
//  result, passing through the input register and then the result register.
//  The string state updates as a byte moves into the result register.
//  Reset: keep_output = 1, byte_limit = 31, decoder waits for an opening quote.
//  A stalled result holds in the result register; one more byte waits in the
//  input register, after which in_i.ready drops.
module json_string_decoder import jsd_pkg::*; #(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  jsd_in_if.sink  in_i,
  jsd_out_if.source out_o,
  jsd_cfg_if.sink cfg_i
);

  // configuration registers
  logic               keep_q;
  logic [LIMIT_W-1:0] limit_q;
  jsd_cfg_t           cfg;

  // input stage
  logic      s1_vq;
  jsd_item_t s1_q;

  // result stage
  logic     o_vq;
  jsd_res_t o_q;
  jsd_res_t res;

  logic o_free, advance;

  assign cfg_i.ready = 1'b1;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= KEEP_OUTPUT_RST;
      limit_q <= BYTE_LIMIT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == REG_KEEP_OUTPUT) keep_q <= cfg_i.wdata[0];
      if (cfg_i.addr == REG_BYTE_LIMIT) limit_q <= cfg_i.wdata[LIMIT_W-1:0];
    end
  end

  assign cfg.keep_output = keep_q;
  assign cfg.byte_limit  = limit_q;

  // pipeline flow control
  assign o_free     = !o_vq || out_o.ready;
  assign advance    = s1_vq && o_free;
  assign in_i.ready = !s1_vq || o_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_vq <= 1'b1;
    end else if (advance) begin
      s1_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.in_byte       <= in_i.in_byte;
      s1_q.end_of_stream <= in_i.end_of_stream;
    end
  end

  // decode state and per-byte logic
  jsd_engine #(
    .LengthBits(LengthBits)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (s1_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vq <= 1'b0;
    end else if (advance) begin
      o_vq <= 1'b1;
    end else if (out_o.ready) begin
      o_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) o_q <= res;
  end

  assign out_o.valid       = o_vq;
  assign out_o.out_data    = o_q.out_data;
  assign out_o.out_count   = o_q.out_count;
  assign out_o.status      = o_q.status;
  assign out_o.done_res    = o_q.done_res;
  assign out_o.kept_length = o_q.kept_length;

  // an invalid string end carries no bytes
  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_INVALID |-> out_o.out_count == 3'd0 &&
    out_o.out_data == '0)
    else $error("invalid result carries data");

  // final status exactly on the string end
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.done_res == (out_o.status != ST_BUSY))
    else $error("done_res and status disagree");

  // validate-only mode emits nothing
  a_validate_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !keep_q |=> out_o.out_count == 3'd0)
    else $error("bytes emitted while validating only");

  // a byte moved on always shows up as a result
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> o_vq)
    else $error("result lost after advance");

endmodule
